// ===== sv/clf_pkg.sv =====
package clf_pkg;

  // Longest line kept, CR and LF included; one cell per byte.
  localparam int LINE_MAX = 64;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] MASK7 = 8'h7F;

  // Commands broadcast to every cell of the line chain.
  typedef struct packed {
    logic clear;   // drop the whole line
    logic shift;   // move every byte one cell toward the output
    logic append;  // first empty cell takes the new byte
  } cell_ctrl_t;

endpackage

// ===== sv/clf_cell.sv =====
module clf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  clf_pkg::cell_ctrl_t        ctrl,
  input  logic                       left_vld,
  input  logic [clf_pkg::BYTE_W-1:0] new_byte,
  input  logic                       right_vld,
  input  logic [clf_pkg::BYTE_W-1:0] right_byte,
  output logic                       vld,
  output logic [clf_pkg::BYTE_W-1:0] data
);
  import clf_pkg::*;

  logic take;

  // Only the first empty cell (left neighbor full) captures a new byte.
  assign take = ctrl.append && left_vld && !vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.clear) begin
      vld <= 1'b0;
    end else if (ctrl.shift) begin
      vld <= right_vld;
    end else if (take) begin
      vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= right_byte;
    end else if (take) begin
      data <= new_byte;
    end
  end

endmodule

// ===== sv/crlf_line_framer.sv =====
// Channel  Dir  Handshake                 Payload
// rx       in   rx_valid / rx_ready       rx_byte
// line     out  line_valid / line_ready   line_byte, line_last
// cfg      in   cfg_wen (no wait)         cfg_wdata -> parity_enabled
//
// Each received byte is appended to the chain. A completed line of at
// most LINE_MAX bytes is then delivered one byte per cycle while
// line_ready is high, from the head cell of the chain; rx_ready is low
// for the whole delivery.
// Synchronous active-high reset empties the line and clears parity mode.
module crlf_line_framer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic                       cfg_wdata,
  input  logic                       rx_valid,
  output logic                       rx_ready,
  input  logic [clf_pkg::BYTE_W-1:0] rx_byte,
  output logic                       line_valid,
  input  logic                       line_ready,
  output logic [clf_pkg::BYTE_W-1:0] line_byte,
  output logic                       line_last
);
  import clf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                   state;
  logic                   state_next;
  logic                   parity_enabled;
  logic                   prev_was_cr;
  logic                   prev_was_cr_next;
  logic [BYTE_W-1:0]      b;
  logic                   rx_req;
  logic                   out_req;
  logic                   is_lf;
  logic                   is_cr;
  cell_ctrl_t             ctrl;
  logic [LINE_MAX-1:0]    vld;
  logic [BYTE_W-1:0]      data [LINE_MAX];

  // Config register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      parity_enabled <= 1'b0;
    end else if (cfg_wen) begin
      parity_enabled <= cfg_wdata;
    end
  end

  // Mask before the LF/CR compare, so 0x8A is an LF with parity on.
  assign b      = parity_enabled ? (rx_byte & MASK7) : rx_byte;
  assign is_lf  = (b == CH_LF);
  assign is_cr  = (b == CH_CR);

  assign rx_ready   = (state == ST_IDLE);
  assign rx_req     = rx_valid && rx_ready;
  assign line_valid = (state == ST_DUMP) && vld[0];
  assign out_req    = line_valid && line_ready;

  // Head cell feeds the output; last byte when its neighbor is empty.
  assign line_byte = data[0];
  assign line_last = !vld[1];

  // Line control. Chain occupancy is a thermometer code in vld:
  //  vld[0] before append  -> line holds >= 2 bytes after append
  //  vld[LINE_MAX-2]       -> line reaches LINE_MAX bytes after append
  always_comb begin
    state_next       = state;
    prev_was_cr_next = prev_was_cr;
    ctrl             = '0;
    unique case (state)
      ST_IDLE: begin
        if (rx_req) begin
          ctrl.append      = 1'b1;
          prev_was_cr_next = is_cr;
          if (is_lf) begin
            prev_was_cr_next = 1'b0;
            if (vld[0] && prev_was_cr) begin
              state_next = ST_DUMP;
            end else begin
              ctrl.clear = 1'b1;   // lone LF drops the line
            end
          end else if (vld[LINE_MAX-2]) begin
            ctrl.clear       = 1'b1; // overlong line
            prev_was_cr_next = 1'b0;
          end
        end
      end
      ST_DUMP: begin
        if (out_req) begin
          ctrl.shift = 1'b1;
          if (line_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev_was_cr <= 1'b0;
    end else begin
      state       <= state_next;
      prev_was_cr <= prev_was_cr_next;
    end
  end

  // Row of byte cells: fill from the left, drain toward cell 0.
  for (genvar i = 0; i < LINE_MAX; i++) begin : g_cell
    logic              left_vld;
    logic              right_vld;
    logic [BYTE_W-1:0] right_byte;

    if (i == 0) begin : g_head
      assign left_vld = 1'b1;
    end else begin : g_body
      assign left_vld = vld[i-1];
    end

    if (i == LINE_MAX - 1) begin : g_tail
      assign right_vld  = 1'b0;
      assign right_byte = '0;
    end else begin : g_mid
      assign right_vld  = vld[i+1];
      assign right_byte = data[i+1];
    end

    clf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_vld   (left_vld),
      .new_byte   (b),
      .right_vld  (right_vld),
      .right_byte (right_byte),
      .vld        (vld[i]),
      .data       (data[i])
    );
  end

  // Occupancy stays a contiguous run starting at cell 0.
  a_thermo: assert property (@(posedge clk) disable iff (rst)
    ((vld >> 1) & ~vld) == '0)
    else $error("line chain has a gap");

  // No byte is taken while a line is being delivered.
  a_no_rx_in_dump: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> !rx_ready)
    else $error("rx accepted during line delivery");

  // A delivered line holds at least CR and LF.
  a_dump_len: assert property (@(posedge clk) disable iff (rst)
    $rose(state) |-> (vld[0] && vld[1]))
    else $error("line shorter than two bytes delivered");

  // After the final LF leaves, the chain is empty and input reopens.
  a_line_done: assert property (@(posedge clk) disable iff (rst)
    (out_req && line_last) |=> (rx_ready && (vld == '0)))
    else $error("chain not empty after line end");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import clf_pkg::*;

  // One byte of a completed line as the block should deliver it.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } line_res_t;

  // Shapes of random traffic. Most of it is well-formed CR LF lines so the
  // framer actually completes lines; the rest breaks the framing.
  typedef enum int {
    LK_TEXT,     // random text, then CR LF
    LK_FULL,     // text that lands the LF exactly on byte LINE_MAX
    LK_OVER,     // LINE_MAX or more bytes with no LF
    LK_BARE_LF,  // short text ending in LF or a high-bit LF code
    LK_NOISE     // a few raw bytes, biased toward CR and LF codes
  } line_kind_t;

  localparam int HOLD_CYCLES = 400;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_wen    = 1'b0;
  logic              cfg_wdata  = 1'b0;
  logic              rx_valid   = 1'b0;
  logic              rx_ready;
  logic [BYTE_W-1:0] rx_byte    = '0;
  logic              line_valid;
  logic              line_ready = 1'b0;
  logic [BYTE_W-1:0] line_byte;
  logic              line_last;

  // Stimulus side: bytes waiting to be offered, and request counters used
  // to tell when the block has swallowed everything.
  logic [BYTE_W-1:0] rx_pend_q[$];
  int                pushed_n = 0;
  int                taken_n  = 0;
  logic              rx_took  = 1'b0;  // rx request accepted at last rising edge

  // Idle percentages, changed per phase by the sequence.
  int unsigned       src_idle_pct  = 0;
  int unsigned       sink_idle_pct = 0;

  // Long stall of the line receiver, timed in its own process.
  logic              hold_go   = 1'b0;
  logic              hold_on   = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_left = 0;

  // Framer shadow state, updated on every accepted rx request.
  logic [BYTE_W-1:0] line_buf[LINE_MAX];
  int                line_fill = 0;
  logic              cr_seen   = 1'b0;
  logic              parity_on = 1'b0;
  line_res_t         line_exp_q[$];

  int                err_n = 0;

  crlf_line_framer u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line_byte  (line_byte),
    .line_last  (line_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow framer: mask, append, then decide whether the line completes,
  // gets dropped, or keeps growing. Completed lines go to line_exp_q whole.
  task automatic frame_byte(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] b;
    line_res_t         r;
    b = parity_on ? (raw & MASK7) : raw;
    if (line_fill < LINE_MAX) begin
      line_buf[line_fill] = b;
      line_fill++;
    end
    if (b == CH_LF) begin
      // only CR LF emits; a bare LF just empties the line
      if (line_fill >= 2 && cr_seen) begin
        for (int k = 0; k < line_fill; k++) begin
          r.data = line_buf[k];
          r.last = (k == line_fill - 1);
          line_exp_q.push_back(r);
        end
      end
      line_fill = 0;
      cr_seen   = 1'b0;
    end else if (line_fill >= LINE_MAX) begin
      // overlong line: dropped silently
      line_fill = 0;
      cr_seen   = 1'b0;
    end else begin
      cr_seen = (b == CH_CR);
    end
  endtask

  // ---------------------------------------------------------------------
  // rx driver: offers queued bytes at the falling edge. A request that is
  // up stays up with the same byte until accepted.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_took) begin
      if (rx_pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        rx_valid <= 1'b1;
        rx_byte  <= rx_pend_q.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // line receiver: random back-pressure, or flat low while a hold runs
  always @(negedge clk) begin
    line_ready <= !rst && !hold_on && ($urandom_range(99) >= sink_idle_pct);
  end

  // One long receiver hold, armed by the sequence via hold_go.
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_on   <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_on) begin
      if (hold_left == 0) begin
        hold_on <= 1'b0;
      end else begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: at each rising edge, feed accepted rx requests to the shadow
  // framer first, then check any accepted line request against the oldest
  // predicted byte. Predicting first allows same-edge output.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    line_res_t want;
    rx_took <= !rst && rx_valid && rx_ready;
    if (!rst && rx_valid && rx_ready) begin
      frame_byte(rx_byte);
      taken_n++;
    end
    if (!rst && line_valid && line_ready) begin
      if (line_exp_q.size() == 0) begin
        if (err_n < 10)
          $display("unexpected line request: byte %h last %b", line_byte, line_last);
        err_n++;
      end else begin
        want = line_exp_q.pop_front();
        if (line_byte !== want.data || line_last !== want.last) begin
          if (err_n < 10)
            $display("line mismatch: byte exp %h got %h, last exp %b got %b",
                     want.data, line_byte, want.last, line_last);
          err_n++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_req(input logic [BYTE_W-1:0] b);
    rx_pend_q.push_back(b);
    pushed_n++;
  endtask

  // Any byte that does not read as LF under the current parity mode.
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(255));
    end while ((parity_on ? (b & MASK7) : b) == CH_LF);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(4))
      0:       return CH_LF;
      1:       return CH_CR;
      2:       return CH_LF | 8'h80;
      3:       return CH_CR | 8'h80;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic add_line(input line_kind_t kind);
    int len;
    case (kind)
      LK_TEXT: begin
        // mostly short lines, now and then a long one
        len = ($urandom_range(9) == 0) ? $urandom_range(LINE_MAX - 2, 40)
                                       : $urandom_range(8, 0);
        repeat (len) push_req(text_byte());
        push_req(CH_CR);
        push_req(CH_LF);
      end
      LK_FULL: begin
        repeat (LINE_MAX - 2) push_req(text_byte());
        push_req(CH_CR);
        push_req(CH_LF);
      end
      LK_OVER: begin
        repeat ($urandom_range(LINE_MAX + 2, LINE_MAX)) push_req(text_byte());
      end
      LK_BARE_LF: begin
        repeat ($urandom_range(3, 0)) push_req(text_byte());
        // high-bit LF is a real LF only with parity on
        push_req($urandom_range(1) ? CH_LF : (CH_LF | 8'h80));
      end
      default: begin
        repeat ($urandom_range(4, 1)) push_req(noise_byte());
      end
    endcase
  endtask

  task automatic random_lines(input int n);
    int         start;
    int unsigned pick;
    start = pushed_n;
    while (pushed_n - start < n) begin
      pick = $urandom_range(99);
      if (pick < 55)      add_line(LK_TEXT);
      else if (pick < 63) add_line(LK_FULL);
      else if (pick < 68) add_line(LK_OVER);
      else if (pick < 82) add_line(LK_BARE_LF);
      else                add_line(LK_NOISE);
    end
  endtask

  // Wait until all requests went in, all predicted bytes came out and no
  // receiver hold runs, then give the block a full line time to settle.
  task automatic wait_drain();
    while (taken_n != pushed_n || line_exp_q.size() != 0 || hold_on)
      @(negedge clk);
    repeat (LINE_MAX + 8) @(negedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic write_parity(input logic v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    parity_on = v;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Phase 0: parity off, directed framing cases; sender 30%, receiver 58%
    src_idle_pct  = 30;
    sink_idle_pct = 58;
    write_parity(1'b0);
    push_req(CH_LF);                          // bare LF as first byte
    push_req(CH_CR); push_req(CH_LF);         // shortest line
    push_req(8'h00); push_req(8'hFF);         // byte extremes inside a line
    push_req(CH_CR); push_req(CH_LF);
    push_req(8'h41); push_req(CH_LF);         // LF after text, no CR
    push_req(CH_CR); push_req(8'h41);         // CR not right before LF
    push_req(CH_LF);
    push_req(8'h8D); push_req(8'h8A);         // high-bit CR/LF are text here
    push_req(CH_CR); push_req(CH_LF);
    push_req(CH_CR); push_req(CH_CR);         // double CR
    push_req(CH_LF);
    wait_drain();

    // Phase 1: parity on, masking makes high-bit codes count as CR/LF
    write_parity(1'b1);
    push_req(8'hFF); push_req(8'h8D); push_req(8'h8A);
    push_req(8'h8A);                          // masked bare LF
    random_lines(8);
    wait_drain();

    // Phase 2: parity off; roles swapped; a long receiver hold while the
    // sender keeps offering, so the block backs up and stalls rx
    src_idle_pct  = 58;
    sink_idle_pct = 30;
    write_parity(1'b0);
    hold_go = 1'b1;
    add_line(LK_FULL);
    add_line(LK_BARE_LF);
    add_line(LK_TEXT);
    wait_drain();

    // Phase 3: parity on, same idling
    write_parity(1'b1);
    add_line(LK_OVER);
    wait_drain();

    // Phase 4: parity off, no idling; sender stops mid-phase until drained
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_parity(1'b0);
    random_lines(4);
    wait_drain();
    add_line(LK_TEXT);
    add_line(LK_NOISE);
    wait_drain();

    // Phase 5: parity on, no idling
    write_parity(1'b1);
    random_lines(4);
    wait_drain();

    if (err_n == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
